### rtl/sawbc_pkg.sv
package sawbc_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 32;
   localparam int SETS       = 4;
   localparam int WAYS       = 2;
   localparam int LINE_WORDS = 8;
   localparam int SET_W      = $clog2(SETS);
   localparam int WAY_W      = $clog2(WAYS);
   localparam int OFS_W      = $clog2(LINE_WORDS);
   localparam int RANK_W     = $clog2(WAYS);
   localparam int BYTE_W     = 2;
   localparam int SET_LO     = BYTE_W + OFS_W;
   localparam int TAG_LO     = SET_LO + SET_W;
   localparam int TAG_W      = ADDR_W - TAG_LO;
   localparam int LINES      = SETS * WAYS;
   localparam int LINE_IDX_W = SET_W + WAY_W;
   localparam int MEM_DEPTH  = LINES * LINE_WORDS;
   localparam int MEM_AW     = LINE_IDX_W + OFS_W;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2,
      OP_FILL  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_READ   = 3'd0,
      KIND_WRITE  = 3'd1,
      KIND_WB     = 3'd2,
      KIND_FETCH  = 3'd3,
      KIND_FLUSH  = 3'd4,
      KIND_REJECT = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_HIT_RSP,
      ST_SCAN,
      ST_WB_RD,
      ST_WB_LD,
      ST_WB_WAIT,
      ST_FETCH,
      ST_FILL_DONE,
      ST_FILL_RSP,
      ST_RSP_WAIT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_REJECT,
      CMD_FLUSH_DONE,
      CMD_HIT_READ,
      CMD_HIT_RSP,
      CMD_HIT_WRITE,
      CMD_MISS_START,
      CMD_WB_READ,
      CMD_WB_RSP,
      CMD_WB_NEXT,
      CMD_FETCH,
      CMD_FILL,
      CMD_FILL_DONE,
      CMD_FILL_RSP,
      CMD_SCAN_SEL
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   pending;
      logic   hit;
      logic   victim_dirty;
      logic   any_dirty;
      logic   other_dirty;
      logic   scan_hit;
      logic   fill_last;
      logic   wb_last;
      logic   pend_write;
      logic   rsp_done;
   } status_type;

endpackage

### rtl/sawbc_ifs.sv
interface sawbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] address;
   logic [31:0] data_word;

   modport source (output valid, operation, address, data_word, input ready);
   modport sink   (input valid, operation, address, data_word, output ready);
endinterface

interface sawbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] mem_address;
   logic [31:0] word_value;
   logic        was_hit;
   logic [1:0]  set_index;
   logic        way_index;
   logic        last;

   modport source (output valid, kind, mem_address, word_value, was_hit, set_index,
                   way_index, last, input ready);
   modport sink   (input valid, kind, mem_address, word_value, was_hit, set_index,
                   way_index, last, output ready);
endinterface

### rtl/set_assoc_writeback_cache_lru.sv
// Write-back, write-allocate, two-way set-associative cache with LRU replacement.
// The req_ch channel carries one operation per transfer: read, write, flush, or a
// fill word that answers an earlier fetch request. The rsp_ch channel carries the
// results: read data, write done, writeback words, fetch requests, flush done, or
// rejected; the last flag marks the final result of each request transfer.
// One item is worked on at a time; req_ch.ready is high only while the
// controller is idle. A read hit goes through the tag compare, a registered line
// memory read and the result load; a write hit writes its word and loads its
// result at the tag compare. Every writeback word goes through a memory read,
// a result load and a result transfer; a dirty miss sends the victim line's
// writeback words before its fetch request, and a flush those of each dirty
// line its scan finds. Each fill word is written in turn; the final fill then
// writes the pending write word, or reads the pending read word for its result.
// When the receiver stalls, the result register holds its word and the
// controller waits; nothing is lost. Reset clears the valid, dirty and recency
// bits, the pending miss, and the result valid flag; line data is not cleared.
module set_assoc_writeback_cache_lru (
   input  logic          clock,
   input  logic          reset,
   sawbc_req_if.sink     req_ch,
   sawbc_rsp_if.source   rsp_ch
);
   import sawbc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   // The controller sequences each operation; the datapath holds all cache state.
   sawbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   sawbc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_ch.operation),
      .req_address     (req_ch.address),
      .req_data_word   (req_ch.data_word),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_kind        (rsp_ch.kind),
      .rsp_mem_address (rsp_ch.mem_address),
      .rsp_word_value  (rsp_ch.word_value),
      .rsp_was_hit     (rsp_ch.was_hit),
      .rsp_set_index   (rsp_ch.set_index),
      .rsp_way_index   (rsp_ch.way_index),
      .rsp_last        (rsp_ch.last),
      .status          (status)
   );

endmodule

### rtl/sawbc_ctrl.sv
module sawbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  sawbc_pkg::status_type  status,
   output logic                   req_ready,
   output sawbc_pkg::cmd_type     cmd
);
   import sawbc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LATCH;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (status.op == OP_FILL) begin
               if (!status.pending) begin
                  cmd      = CMD_REJECT;
                  state_in = ST_RSP_WAIT;
               end else begin
                  cmd      = CMD_FILL;
                  state_in = status.fill_last ? ST_FILL_DONE : ST_IDLE;
               end
            end else if (status.pending) begin
               cmd      = CMD_REJECT;
               state_in = ST_RSP_WAIT;
            end else if (status.op == OP_FLUSH) begin
               if (status.any_dirty) begin
                  state_in = ST_SCAN;
               end else begin
                  cmd      = CMD_FLUSH_DONE;
                  state_in = ST_RSP_WAIT;
               end
            end else if (status.hit) begin
               if (status.op == OP_READ) begin
                  cmd      = CMD_HIT_READ;
                  state_in = ST_HIT_RSP;
               end else begin
                  cmd      = CMD_HIT_WRITE;
                  state_in = ST_RSP_WAIT;
               end
            end else begin
               cmd      = CMD_MISS_START;
               state_in = status.victim_dirty ? ST_WB_RD : ST_FETCH;
            end
         end
         ST_HIT_RSP: begin
            cmd      = CMD_HIT_RSP;
            state_in = ST_RSP_WAIT;
         end
         ST_SCAN: begin
            if (status.scan_hit) begin
               cmd      = CMD_SCAN_SEL;
               state_in = ST_WB_RD;
            end else begin
               cmd = CMD_WB_NEXT;
            end
         end
         ST_WB_RD: begin
            cmd      = CMD_WB_READ;
            state_in = ST_WB_LD;
         end
         ST_WB_LD: begin
            cmd      = CMD_WB_RSP;
            state_in = ST_WB_WAIT;
         end
         ST_WB_WAIT: begin
            if (status.rsp_done) begin
               cmd = CMD_WB_NEXT;
               priority if (!status.wb_last) begin
                  state_in = ST_WB_RD;
               end else if (status.op == OP_FLUSH) begin
                  state_in = status.other_dirty ? ST_SCAN : ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd      = CMD_FETCH;
            state_in = ST_RSP_WAIT;
         end
         ST_FILL_DONE: begin
            cmd      = CMD_FILL_DONE;
            state_in = status.pend_write ? ST_RSP_WAIT : ST_FILL_RSP;
         end
         ST_FILL_RSP: begin
            cmd      = CMD_FILL_RSP;
            state_in = ST_RSP_WAIT;
         end
         ST_RSP_WAIT: begin
            if (status.rsp_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/sawbc_dp.sv
module sawbc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sawbc_pkg::cmd_type     cmd,
   input  logic [1:0]             req_operation,
   input  logic [15:0]            req_address,
   input  logic [31:0]            req_data_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_kind,
   output logic [15:0]            rsp_mem_address,
   output logic [31:0]            rsp_word_value,
   output logic                   rsp_was_hit,
   output logic [1:0]             rsp_set_index,
   output logic                   rsp_way_index,
   output logic                   rsp_last,
   output sawbc_pkg::status_type  status
);
   import sawbc_pkg::*;

   // Latched request.
   logic [1:0]        req_op_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [DATA_W-1:0] req_data_ff;

   // Tag store, one entry per line, indexed by {set, way}.
   logic              valid_ff [LINES];
   logic              dirty_ff [LINES];
   logic [TAG_W-1:0]  tag_ff   [LINES];
   logic [RANK_W-1:0] rank_ff  [LINES];

   // Miss bookkeeping and sequencing counters.
   logic                  pending_ff;
   logic                  pend_write_ff;
   logic [ADDR_W-1:0]     pend_addr_ff;
   logic [DATA_W-1:0]     pend_data_ff;
   logic [OFS_W-1:0]      fill_cnt_ff;
   logic [LINE_IDX_W-1:0] line_ff;
   logic [OFS_W-1:0]      word_cnt_ff;
   logic [LINE_IDX_W-1:0] scan_ff;

   // Line data memory.
   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic [2:0]        rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SET_W-1:0]  rsp_set_ff, rsp_set_in;
   logic [WAY_W-1:0]  rsp_way_ff, rsp_way_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_load;

   logic [OFS_W-1:0] req_word;
   logic [SET_W-1:0] req_set;
   logic [TAG_W-1:0] req_tag;
   logic [OFS_W-1:0] pend_word;
   logic [TAG_W-1:0] pend_tag;
   logic [SET_W-1:0] line_set;
   logic [WAY_W-1:0] line_way;

   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic             found_free;
   logic [WAY_W-1:0] victim;
   logic [LINES-1:0] dirty_vec;
   logic [LINES-1:0] line_onehot;

   logic                  mem_we;
   logic [MEM_AW-1:0]     mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic                  mem_re;
   logic [MEM_AW-1:0]     mem_raddr;
   logic                  touch_en;
   logic [SET_W-1:0]      touch_set;
   logic [WAY_W-1:0]      touch_way;
   logic [RANK_W-1:0]     touch_rank;
   logic                  rsp_done;

   assign req_word  = req_addr_ff[SET_LO-1:BYTE_W];
   assign req_set   = req_addr_ff[TAG_LO-1:SET_LO];
   assign req_tag   = req_addr_ff[ADDR_W-1:TAG_LO];
   assign pend_word = pend_addr_ff[SET_LO-1:BYTE_W];
   assign pend_tag  = pend_addr_ff[ADDR_W-1:TAG_LO];
   assign line_set  = line_ff[LINE_IDX_W-1:WAY_W];
   assign line_way  = line_ff[WAY_W-1:0];
   assign rsp_done  = rsp_valid_ff && rsp_ready;

   // Hit detection and victim choice within the requested set.
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      found_free = 1'b0;
      victim     = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && valid_ff[{req_set, WAY_W'(w)}] &&
             tag_ff[{req_set, WAY_W'(w)}] == req_tag) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!found_free && !valid_ff[{req_set, WAY_W'(w)}]) begin
            found_free = 1'b1;
            victim     = WAY_W'(w);
         end
      end
      if (!found_free) begin
         for (int w = 1; w < WAYS; w++) begin
            if (rank_ff[{req_set, WAY_W'(w)}] > rank_ff[{req_set, victim}]) begin
               victim = WAY_W'(w);
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LINES; l++) begin
         dirty_vec[l]   = valid_ff[l] && dirty_ff[l];
         line_onehot[l] = (line_ff == LINE_IDX_W'(l));
      end
   end

   assign status.op           = op_type'(req_op_ff);
   assign status.pending      = pending_ff;
   assign status.hit          = hit;
   assign status.victim_dirty = dirty_vec[{req_set, victim}];
   assign status.any_dirty    = |dirty_vec;
   assign status.other_dirty  = |(dirty_vec & ~line_onehot);
   assign status.scan_hit     = dirty_vec[scan_ff];
   assign status.fill_last    = (fill_cnt_ff == OFS_W'(LINE_WORDS - 1));
   assign status.wb_last      = (word_cnt_ff == OFS_W'(LINE_WORDS - 1));
   assign status.pend_write   = pend_write_ff;
   assign status.rsp_done     = rsp_done;

   // Memory port, recency update and result selection per command.
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = {line_ff, fill_cnt_ff};
      mem_wdata    = req_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = {line_ff, word_cnt_ff};
      touch_en     = 1'b0;
      touch_set    = req_set;
      touch_way    = hit_way;
      rsp_load     = 1'b0;
      rsp_kind_in  = KIND_REJECT;
      rsp_addr_in  = req_addr_ff;
      rsp_value_in = '0;
      rsp_hit_in   = 1'b0;
      rsp_set_in   = '0;
      rsp_way_in   = '0;
      rsp_last_in  = 1'b1;
      unique case (cmd)
         CMD_REJECT: begin
            rsp_load = 1'b1;
         end
         CMD_FLUSH_DONE: begin
            rsp_load    = 1'b1;
            rsp_kind_in = KIND_FLUSH;
            rsp_addr_in = '0;
         end
         CMD_HIT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = {req_set, hit_way, req_word};
            touch_en  = 1'b1;
         end
         CMD_HIT_RSP: begin
            rsp_load     = 1'b1;
            rsp_kind_in  = KIND_READ;
            rsp_addr_in  = {req_addr_ff[ADDR_W-1:BYTE_W], BYTE_W'(0)};
            rsp_value_in = rd_data_ff;
            rsp_hit_in   = 1'b1;
            rsp_set_in   = line_set;
            rsp_way_in   = line_way;
         end
         CMD_HIT_WRITE: begin
            mem_we      = 1'b1;
            mem_waddr   = {req_set, hit_way, req_word};
            touch_en    = 1'b1;
            rsp_load    = 1'b1;
            rsp_kind_in = KIND_WRITE;
            rsp_addr_in = {req_addr_ff[ADDR_W-1:BYTE_W], BYTE_W'(0)};
            rsp_hit_in  = 1'b1;
            rsp_set_in  = req_set;
            rsp_way_in  = hit_way;
         end
         CMD_WB_READ: begin
            mem_re = 1'b1;
         end
         CMD_WB_RSP: begin
            rsp_load     = 1'b1;
            rsp_kind_in  = KIND_WB;
            rsp_addr_in  = {tag_ff[line_ff], line_set, word_cnt_ff, BYTE_W'(0)};
            rsp_value_in = rd_data_ff;
            rsp_set_in   = line_set;
            rsp_way_in   = line_way;
            rsp_last_in  = (req_op_ff == OP_FLUSH) && !status.other_dirty &&
                           status.wb_last;
         end
         CMD_FETCH: begin
            rsp_load    = 1'b1;
            rsp_kind_in = KIND_FETCH;
            rsp_addr_in = {req_addr_ff[ADDR_W-1:SET_LO], SET_LO'(0)};
            rsp_set_in  = line_set;
            rsp_way_in  = line_way;
         end
         CMD_FILL: begin
            mem_we = 1'b1;
         end
         CMD_FILL_DONE: begin
            touch_en  = 1'b1;
            touch_set = line_set;
            touch_way = line_way;
            mem_waddr = {line_ff, pend_word};
            mem_wdata = pend_data_ff;
            mem_raddr = {line_ff, pend_word};
            if (pend_write_ff) begin
               mem_we      = 1'b1;
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_WRITE;
               rsp_addr_in = {pend_addr_ff[ADDR_W-1:BYTE_W], BYTE_W'(0)};
               rsp_set_in  = line_set;
               rsp_way_in  = line_way;
            end else begin
               mem_re = 1'b1;
            end
         end
         CMD_FILL_RSP: begin
            rsp_load     = 1'b1;
            rsp_kind_in  = KIND_READ;
            rsp_addr_in  = {pend_addr_ff[ADDR_W-1:BYTE_W], BYTE_W'(0)};
            rsp_value_in = rd_data_ff;
            rsp_set_in   = line_set;
            rsp_way_in   = line_way;
         end
         default: begin
         end
      endcase
   end

   assign touch_rank = rank_ff[{touch_set, touch_way}];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LINES; l++) begin
            valid_ff[l] <= 1'b0;
            dirty_ff[l] <= 1'b0;
            rank_ff[l]  <= '0;
         end
         pending_ff   <= 1'b0;
         fill_cnt_ff  <= '0;
         word_cnt_ff  <= '0;
         scan_ff      <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (touch_en) begin
            for (int v = 0; v < WAYS; v++) begin
               if (WAY_W'(v) == touch_way) begin
                  rank_ff[{touch_set, WAY_W'(v)}] <= '0;
               end else if (rank_ff[{touch_set, WAY_W'(v)}] <= touch_rank &&
                            rank_ff[{touch_set, WAY_W'(v)}] < RANK_W'(WAYS - 1)) begin
                  rank_ff[{touch_set, WAY_W'(v)}] <=
                     rank_ff[{touch_set, WAY_W'(v)}] + RANK_W'(1);
               end
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_done) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd)
            CMD_LATCH: begin
               scan_ff <= '0;
            end
            CMD_HIT_READ: begin
               line_ff <= {req_set, hit_way};
            end
            CMD_HIT_WRITE: begin
               dirty_ff[{req_set, hit_way}] <= 1'b1;
            end
            CMD_MISS_START: begin
               line_ff     <= {req_set, victim};
               word_cnt_ff <= '0;
            end
            CMD_SCAN_SEL: begin
               line_ff     <= scan_ff;
               word_cnt_ff <= '0;
            end
            CMD_WB_NEXT: begin
               if (cmd == CMD_WB_NEXT && (status.wb_last || !status.scan_hit)) begin
                  scan_ff <= scan_ff + LINE_IDX_W'(1);
               end
               word_cnt_ff <= word_cnt_ff + OFS_W'(1);
               if (status.wb_last && status.scan_hit) begin
                  dirty_ff[line_ff] <= 1'b0;
               end
            end
            CMD_FETCH: begin
               valid_ff[line_ff] <= 1'b0;
               dirty_ff[line_ff] <= 1'b0;
               pending_ff        <= 1'b1;
               fill_cnt_ff       <= '0;
            end
            CMD_FILL: begin
               fill_cnt_ff <= fill_cnt_ff + OFS_W'(1);
            end
            CMD_FILL_DONE: begin
               pending_ff        <= 1'b0;
               valid_ff[line_ff] <= 1'b1;
               dirty_ff[line_ff] <= pend_write_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd == CMD_LATCH) begin
         req_op_ff   <= req_operation;
         req_addr_ff <= req_address;
         req_data_ff <= req_data_word;
      end
      if (cmd == CMD_FETCH) begin
         pend_write_ff <= (req_op_ff == OP_WRITE);
         pend_addr_ff  <= req_addr_ff;
         pend_data_ff  <= req_data_ff;
      end
      if (cmd == CMD_FILL_DONE) begin
         tag_ff[line_ff] <= pend_tag;
      end
      if (rsp_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_value_ff <= rsp_value_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_set_ff   <= rsp_set_in;
         rsp_way_ff   <= rsp_way_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_mem_address = rsp_addr_ff;
   assign rsp_word_value  = rsp_value_ff;
   assign rsp_was_hit     = rsp_hit_ff;
   assign rsp_set_index   = rsp_set_ff;
   assign rsp_way_index   = rsp_way_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import sawbc_pkg::*;

   // One result word as it leaves the cache.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] mem_address;
      logic [31:0] word_value;
      logic        was_hit;
      logic [1:0]  set_index;
      logic        way_index;
      logic        last;
   } cache_rsp_t;

   // One row of the directed table. A row with typed set carries its own
   // expected result; every other row is checked against the shadow cache.
   // A row with count above one is sent that many times, the data word
   // being stepped by the repeat index each time (used for fill bursts).
   typedef struct {
      op_type      op;
      logic [15:0] addr;
      logic [31:0] data;
      int          count;
      bit          typed;
      cache_rsp_t  rsp;
   } dir_row_t;

   localparam int IDLE_PCT   = 23;
   localparam int RAND_ITEMS = 384;
   localparam int STALL_LIM  = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sawbc_req_if req_ch ();
   sawbc_rsp_if rsp_ch ();

   set_assoc_writeback_cache_lru u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #1 clock = ~clock;

   // Shadow copy of the cache: tag store, line data, recency ranks and the
   // outstanding miss that the fill words are answering.
   logic             sh_valid [LINES];
   logic             sh_dirty [LINES];
   logic [TAG_W-1:0] sh_tag   [LINES];
   logic [31:0]      sh_words [MEM_DEPTH];
   int               sh_rank  [LINES];
   logic             sh_miss;
   op_type           pend_op;
   logic [15:0]      pend_addr;
   logic [31:0]      pend_data;
   int               pend_set;
   int               pend_way;
   logic [TAG_W-1:0] pend_tag;
   int               fill_cnt;

   cache_rsp_t expected_rsps[$];
   cache_rsp_t scratch_rsps[$];
   int         mismatches = 0;
   bit         calm = 1'b0;

   // Appends one result to the scratch list built for the current transfer.
   function automatic void emit(kind_type k, logic [15:0] a, logic [31:0] v,
                                logic h, int s, int w, logic l);
      cache_rsp_t r;
      r.kind        = k;
      r.mem_address = a;
      r.word_value  = v;
      r.was_hit     = h;
      r.set_index   = s[1:0];
      r.way_index   = w[0];
      r.last        = l;
      scratch_rsps.push_back(r);
   endfunction

   // Marks a way most recently used; ways that were no older move one step older.
   function automatic void touch_way(int s, int w);
      int r;
      r = sh_rank[s*WAYS + w];
      for (int v = 0; v < WAYS; v++)
         if (v != w && sh_rank[s*WAYS + v] <= r && sh_rank[s*WAYS + v] < WAYS - 1)
            sh_rank[s*WAYS + v]++;
      sh_rank[s*WAYS + w] = 0;
   endfunction

   // Sends a whole line out as writeback words and cleans it.
   function automatic void evict_line(int s, int w, bit mark_last);
      int          li;
      logic [15:0] base;
      li   = s*WAYS + w;
      base = {sh_tag[li], s[SET_W-1:0], {SET_LO{1'b0}}};
      for (int i = 0; i < LINE_WORDS; i++)
         emit(KIND_WB, base + 16'(4*i), sh_words[li*LINE_WORDS + i], 1'b0, s, w,
              mark_last && i == LINE_WORDS - 1);
      sh_dirty[li] = 1'b0;
   endfunction

   function automatic void reset_shadow();
      for (int i = 0; i < LINES; i++) begin
         sh_valid[i] = 1'b0;
         sh_dirty[i] = 1'b0;
         sh_tag[i]   = '0;
         sh_rank[i]  = 0;
      end
      for (int i = 0; i < MEM_DEPTH; i++)
         sh_words[i] = '0;
      sh_miss  = 1'b0;
      fill_cnt = 0;
   endfunction

   // Works out every result that one accepted request causes and updates
   // the shadow cache; the results are left in scratch_rsps.
   function automatic void cache_predict(op_type op, logic [15:0] addr, logic [31:0] data);
      int               wofs, s, li, victim, total, done;
      logic [TAG_W-1:0] t;
      wofs = addr[SET_LO-1:BYTE_W];
      s    = addr[TAG_LO-1:SET_LO];
      t    = addr[ADDR_W-1:TAG_LO];
      scratch_rsps.delete();
      if (op == OP_FILL) begin
         if (!sh_miss) begin
            emit(KIND_REJECT, addr, '0, 1'b0, 0, 0, 1'b1);
            return;
         end
         li = pend_set*WAYS + pend_way;
         sh_words[li*LINE_WORDS + fill_cnt] = data;
         fill_cnt++;
         if (fill_cnt < LINE_WORDS)
            return;
         fill_cnt     = 0;
         sh_miss      = 1'b0;
         sh_valid[li] = 1'b1;
         sh_tag[li]   = pend_tag;
         touch_way(pend_set, pend_way);
         wofs = pend_addr[SET_LO-1:BYTE_W];
         if (pend_op == OP_READ) begin
            sh_dirty[li] = 1'b0;
            emit(KIND_READ, pend_addr & 16'hFFFC, sh_words[li*LINE_WORDS + wofs], 1'b0,
                 pend_set, pend_way, 1'b1);
         end else begin
            sh_words[li*LINE_WORDS + wofs] = pend_data;
            sh_dirty[li] = 1'b1;
            emit(KIND_WRITE, pend_addr & 16'hFFFC, '0, 1'b0, pend_set, pend_way, 1'b1);
         end
         return;
      end
      if (sh_miss) begin
         emit(KIND_REJECT, addr, '0, 1'b0, 0, 0, 1'b1);
         return;
      end
      if (op == OP_FLUSH) begin
         total = 0;
         done  = 0;
         for (int i = 0; i < LINES; i++)
            if (sh_valid[i] && sh_dirty[i])
               total++;
         if (total == 0) begin
            emit(KIND_FLUSH, '0, '0, 1'b0, 0, 0, 1'b1);
            return;
         end
         for (int ss = 0; ss < SETS; ss++)
            for (int w = 0; w < WAYS; w++)
               if (sh_valid[ss*WAYS + w] && sh_dirty[ss*WAYS + w]) begin
                  done++;
                  evict_line(ss, w, done == total);
               end
         return;
      end
      for (int w = 0; w < WAYS; w++) begin
         li = s*WAYS + w;
         if (sh_valid[li] && sh_tag[li] == t) begin
            touch_way(s, w);
            if (op == OP_READ) begin
               emit(KIND_READ, addr & 16'hFFFC, sh_words[li*LINE_WORDS + wofs], 1'b1,
                    s, w, 1'b1);
            end else begin
               sh_words[li*LINE_WORDS + wofs] = data;
               sh_dirty[li] = 1'b1;
               emit(KIND_WRITE, addr & 16'hFFFC, '0, 1'b1, s, w, 1'b1);
            end
            return;
         end
      end
      // Miss: lowest invalid way, else the oldest one.
      victim = WAYS;
      for (int w = 0; w < WAYS; w++)
         if (!sh_valid[s*WAYS + w] && victim == WAYS)
            victim = w;
      if (victim == WAYS) begin
         victim = 0;
         for (int w = 1; w < WAYS; w++)
            if (sh_rank[s*WAYS + w] > sh_rank[s*WAYS + victim])
               victim = w;
      end
      li = s*WAYS + victim;
      if (sh_valid[li] && sh_dirty[li])
         evict_line(s, victim, 1'b0);
      sh_valid[li] = 1'b0;
      sh_dirty[li] = 1'b0;
      pend_op   = op;
      pend_addr = addr;
      pend_data = data;
      pend_set  = s;
      pend_way  = victim;
      pend_tag  = t;
      sh_miss   = 1'b1;
      fill_cnt  = 0;
      emit(KIND_FETCH, addr & ~16'(LINE_WORDS*4 - 1), '0, 1'b0, s, victim, 1'b1);
   endfunction

   // Drives one request and waits for its transfer. Apart from the end of the run,
   // valid is only lowered here when an idle gap is taken, so it never drops and rises in one step.
   task automatic send_req(op_type op, logic [15:0] addr, logic [31:0] data);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.address   <= addr;
      req_ch.data_word <= data;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Sends a request and queues the shadow cache's results for it.
   task automatic run_req(op_type op, logic [15:0] addr, logic [31:0] data);
      send_req(op, addr, data);
      cache_predict(op, addr, data);
      foreach (scratch_rsps[i])
         expected_rsps.push_back(scratch_rsps[i]);
   endtask

   function automatic cache_rsp_t mk_rsp(kind_type k, logic [15:0] a, int s, int w);
      cache_rsp_t r;
      r.kind        = k;
      r.mem_address = a;
      r.word_value  = '0;
      r.was_hit     = 1'b0;
      r.set_index   = s[1:0];
      r.way_index   = w[0];
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic dir_row_t row(op_type op, logic [15:0] a, logic [31:0] d, int n);
      dir_row_t r;
      r.op    = op;
      r.addr  = a;
      r.data  = d;
      r.count = n;
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic dir_row_t trow(op_type op, logic [15:0] a, logic [31:0] d,
                                     cache_rsp_t x);
      dir_row_t r;
      r       = row(op, a, d, 1);
      r.typed = 1'b1;
      r.rsp   = x;
      return r;
   endfunction

   task automatic report_mismatch(string what, cache_rsp_t got, cache_rsp_t want);
      mismatches++;
      $write("ERROR %s: got kind %0d addr %h val %h hit %b set %0d way %0d last %b, ",
             what, got.kind, got.mem_address, got.word_value, got.was_hit,
             got.set_index, got.way_index, got.last);
      $display("want kind %0d addr %h val %h hit %b set %0d way %0d last %b",
               want.kind, want.mem_address, want.word_value, want.was_hit,
               want.set_index, want.way_index, want.last);
   endtask

   // The receiver stalls at random except inside the calm stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // Result checker: every result transfer is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      cache_rsp_t got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind        = kind_type'(rsp_ch.kind);
         got.mem_address = rsp_ch.mem_address;
         got.word_value  = rsp_ch.word_value;
         got.was_hit     = rsp_ch.was_hit;
         got.set_index   = rsp_ch.set_index;
         got.way_index   = rsp_ch.way_index;
         got.last        = rsp_ch.last;
         if (expected_rsps.size() == 0) begin
            want = got;
            report_mismatch("unexpected result", got, want);
         end else begin
            want = expected_rsps.pop_front();
            if (got != want)
               report_mismatch("result differs", got, want);
         end
      end
   end

   // Watchdog: too many cycles in a row with no transfer on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIM) begin
         $display("set_assoc_writeback_cache_lru: mismatch");
         $finish;
      end
   end

   initial begin
      dir_row_t    dir_rows[$];
      dir_row_t    r;
      int          items, calm_lo, pick, s;
      logic [15:0] a;
      logic [8:0]  t;

      req_ch.valid     = 1'b0;
      req_ch.operation = OP_READ;
      req_ch.address   = '0;
      req_ch.data_word = '0;
      reset_shadow();

      // A stray fill, an empty flush, an unaligned read miss, requests while
      // the miss is pending, then fills, misses and hits at the address extremes.
      dir_rows.push_back(trow(OP_FILL, 16'hFFFF, 32'h0,
                              mk_rsp(KIND_REJECT, 16'hFFFF, 0, 0)));
      dir_rows.push_back(trow(OP_FLUSH, 16'h0, 32'h0, mk_rsp(KIND_FLUSH, 16'h0, 0, 0)));
      dir_rows.push_back(trow(OP_READ, 16'h0003, 32'hFFFFFFFF,
                              mk_rsp(KIND_FETCH, 16'h0, 0, 0)));
      dir_rows.push_back(trow(OP_WRITE, 16'h1234, 32'h5,
                              mk_rsp(KIND_REJECT, 16'h1234, 0, 0)));
      dir_rows.push_back(trow(OP_FLUSH, 16'hABCD, 32'h0,
                              mk_rsp(KIND_REJECT, 16'hABCD, 0, 0)));
      dir_rows.push_back(row(OP_FILL, 16'hFFFF, 32'hFFFFFFF8, 8));
      dir_rows.push_back(row(OP_READ, 16'h001F, 32'h0, 1));
      dir_rows.push_back(trow(OP_WRITE, 16'hFFFF, 32'hFFFFFFFF,
                              mk_rsp(KIND_FETCH, 16'hFFE0, 3, 0)));
      dir_rows.push_back(row(OP_FILL, 16'h0, 32'h0, 8));
      dir_rows.push_back(row(OP_READ, 16'hFFFC, 32'h0, 1));
      dir_rows.push_back(row(OP_WRITE, 16'h0004, 32'hA5A5A5A5, 1));
      dir_rows.push_back(row(OP_WRITE, 16'hFF80, 32'h12345678, 1));
      dir_rows.push_back(row(OP_FILL, 16'h0, 32'h80000000, 8));
      // A second tag in set 3 takes the free way next to the dirty line.
      dir_rows.push_back(row(OP_READ, 16'h7FE0, 32'h0, 1));
      dir_rows.push_back(row(OP_FILL, 16'h0, 32'h7FFFFFFF, 8));
      dir_rows.push_back(row(OP_FLUSH, 16'h0, 32'h0, 1));
      dir_rows.push_back(row(OP_FLUSH, 16'h0, 32'h0, 1));
      dir_rows.push_back(row(OP_READ, 16'h0004, 32'h0, 1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         for (int k = 0; k < r.count; k++) begin
            if (r.typed) begin
               send_req(r.op, r.addr, r.data);
               cache_predict(r.op, r.addr, r.data);
               expected_rsps.push_back(r.rsp);
            end else begin
               run_req(r.op, r.addr, r.data + 32'(k));
            end
         end
      end

      // Random part: mostly complete accesses over a small pool of tags so
      // that hits, evictions and writebacks are frequent, with fill bursts
      // for every miss and some stray or out-of-turn items mixed in.
      calm_lo = $urandom_range(100, 250);
      items   = 0;
      while (items < RAND_ITEMS) begin
         calm = (items >= calm_lo && items < calm_lo + 80);
         pick = $urandom_range(99);
         if (sh_miss) begin
            if (pick < 92)
               run_req(OP_FILL, 16'($urandom), $urandom);
            else
               run_req(op_type'($urandom_range(2)), 16'($urandom), $urandom);
         end else if (pick < 4) begin
            run_req(OP_FILL, 16'($urandom), $urandom);
         end else if (pick < 10) begin
            run_req(OP_FLUSH, 16'($urandom), $urandom);
         end else begin
            if ($urandom_range(9) == 0) begin
               a = 16'($urandom);
            end else begin
               t = 9'($urandom_range(2));
               s = $urandom_range(SETS - 1);
               a = {t, s[1:0], 5'($urandom)};
            end
            run_req(op_type'($urandom_range(1)), a, $urandom);
         end
         items++;
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0)
         $display("set_assoc_writeback_cache_lru: match");
      else
         $display("set_assoc_writeback_cache_lru: mismatch");
      $finish;
   end

endmodule

### files.f
rtl/sawbc_pkg.sv
rtl/sawbc_ifs.sv
rtl/sawbc_ctrl.sv
rtl/sawbc_dp.sv
rtl/set_assoc_writeback_cache_lru.sv
verif/tb_top.sv
